FILE: src/xcd_pkg.sv
// Shared types and constants of the XTEA-CTR container decryptor.
// Used by the front parser, the back end and the top level.
`default_nettype none
package xcd_pkg;

	localparam int unsigned HdrSize   = 24;
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned XteaRounds = 32;

	localparam logic [31:0] XteaDelta = 32'h9e37_79b9;
	localparam logic [31:0] CrcPoly   = 32'hedb8_8320;

	localparam logic [7:0] Magic0 = 8'h46;
	localparam logic [7:0] Magic1 = 8'h57;
	localparam logic [7:0] Magic2 = 8'h58;
	localparam logic [7:0] Magic3 = 8'h42;
	localparam logic [7:0] FmtVersion = 8'h01;
	localparam logic [7:0] AlgXteaCtr = 8'h01;

	localparam logic [31:0] KeyReset0 = 32'h8f4c_29a1;
	localparam logic [31:0] KeyReset1 = 32'h73b6_d502;
	localparam logic [31:0] KeyReset2 = 32'hc14e_87f3;
	localparam logic [31:0] KeyReset3 = 32'h2ad9_5b60;
	localparam logic [23:0] MaxLenReset = 24'd1048576;

	localparam logic [2:0] RegKey0   = 3'd0;
	localparam logic [2:0] RegKey1   = 3'd1;
	localparam logic [2:0] RegKey2   = 3'd2;
	localparam logic [2:0] RegKey3   = 3'd3;
	localparam logic [2:0] RegMaxLen = 3'd4;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_HDR = 2'd1,
		ST_BAD_LEN = 2'd2,
		ST_BAD_CRC = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [2:0]  lane;
		logic        new_blk;
		logic [63:0] ctr;
		logic        emit;
		logic        last;
		status_t     pre_status;
		logic [31:0] expected;
	} entry_t;

endpackage
`default_nettype wire

FILE: src/xcd_fifo.sv
// Small word queue between the front parser and the back end.
// Generic width and depth; no package dependencies.
`default_nettype none
module xcd_fifo #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [Width-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [Width-1:0]      rdata
);
	localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

	logic [Width-1:0] mem_q [Depth];
	logic [Aw-1:0]    wr_ptr_q, rd_ptr_q;
	logic [Aw:0]      cnt_q;

	assign full      = (cnt_q == (Aw+1)'(Depth));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Aw'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Aw'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/xcd_front.sv
// Front parser: checks the container header, tracks the payload position
// and classifies each byte into a queue word. Depends on xcd_pkg.
`default_nettype none
module xcd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr_en,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_wdata,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    file_byte,
	input  wire logic          last_byte,
	input  wire logic          q_full,
	output logic               q_push,
	output xcd_pkg::entry_t    q_word
);
	import xcd_pkg::*;

	logic [23:0] max_len_q;
	logic [24:0] idx_q;
	logic        hbad_q;
	logic [31:0] decl_q;
	logic [31:0] exp_q;
	logic [63:0] ctr_q;

	logic        acc;
	logic [24:0] idx_nx, pos;
	logic        hbad_nx;
	logic [31:0] decl_nx, exp_nx;
	logic [63:0] ctr_nx;
	logic        len_ok, emit, new_blk;
	status_t     pre;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign pos      = idx_q - 25'(HdrSize);
	assign len_ok   = (decl_q != '0) && (decl_q <= {8'b0, max_len_q});
	assign idx_nx   = (idx_q == '1) ? idx_q : idx_q + 1'b1;

	always_comb begin
		hbad_nx = hbad_q;
		decl_nx = decl_q;
		exp_nx  = exp_q;
		ctr_nx  = ctr_q;
		emit    = 1'b0;
		new_blk = 1'b0;
		if (idx_q < 25'(HdrSize)) begin
			case (idx_q[4:0])
				5'd0: hbad_nx = hbad_q | (file_byte != Magic0);
				5'd1: hbad_nx = hbad_q | (file_byte != Magic1);
				5'd2: hbad_nx = hbad_q | (file_byte != Magic2);
				5'd3: hbad_nx = hbad_q | (file_byte != Magic3);
				5'd4: hbad_nx = hbad_q | (file_byte != FmtVersion);
				5'd5: hbad_nx = hbad_q | (file_byte != AlgXteaCtr);
				5'd6: hbad_nx = hbad_q | (file_byte != 8'(HdrSize));
				5'd7: hbad_nx = hbad_q | (file_byte != 8'(HdrSize >> 8));
				5'd8:  decl_nx[7:0]   = file_byte;
				5'd9:  decl_nx[15:8]  = file_byte;
				5'd10: decl_nx[23:16] = file_byte;
				5'd11: decl_nx[31:24] = file_byte;
				5'd12: exp_nx[7:0]    = file_byte;
				5'd13: exp_nx[15:8]   = file_byte;
				5'd14: exp_nx[23:16]  = file_byte;
				5'd15: exp_nx[31:24]  = file_byte;
				5'd16: ctr_nx[7:0]    = file_byte;
				5'd17: ctr_nx[15:8]   = file_byte;
				5'd18: ctr_nx[23:16]  = file_byte;
				5'd19: ctr_nx[31:24]  = file_byte;
				5'd20: ctr_nx[39:32]  = file_byte;
				5'd21: ctr_nx[47:40]  = file_byte;
				5'd22: ctr_nx[55:48]  = file_byte;
				default: ctr_nx[63:56] = file_byte;
			endcase
		end else begin
			emit = !hbad_q && len_ok && ({7'b0, pos} < decl_q);
			new_blk = emit && (pos[2:0] == 3'd0);
			if (new_blk) begin
				ctr_nx = ctr_q + 64'd1;
			end
		end
	end

	always_comb begin
		if ((idx_nx < 25'(HdrSize)) || hbad_nx) begin
			pre = ST_BAD_HDR;
		end else if (!len_ok || ({8'b0, idx_nx} != ({1'b0, decl_q} + 33'(HdrSize)))) begin
			pre = ST_BAD_LEN;
		end else begin
			pre = ST_OK;
		end
	end

	assign q_push             = acc && (emit || last_byte);
	assign q_word.data        = file_byte;
	assign q_word.lane        = pos[2:0];
	assign q_word.new_blk     = new_blk;
	assign q_word.ctr         = ctr_q;
	assign q_word.emit        = emit;
	assign q_word.last        = last_byte;
	assign q_word.pre_status  = pre;
	assign q_word.expected    = exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxLenReset;
			idx_q     <= '0;
			hbad_q    <= 1'b0;
			decl_q    <= '0;
			exp_q     <= '0;
			ctr_q     <= '0;
		end else begin
			if (cfg_wr_en && (cfg_index == RegMaxLen)) begin
				max_len_q <= cfg_wdata[23:0];
			end
			if (acc) begin
				if (last_byte) begin
					idx_q  <= '0;
					hbad_q <= 1'b0;
					decl_q <= '0;
					exp_q  <= '0;
					ctr_q  <= '0;
				end else begin
					idx_q  <= idx_nx;
					hbad_q <= hbad_nx;
					decl_q <= decl_nx;
					exp_q  <= exp_nx;
					ctr_q  <= ctr_nx;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/xcd_back.sv
// Back end: XTEA keystream generator (one round per cycle), payload XOR,
// CRC-32 and the output register. Depends on xcd_pkg.
`default_nettype none
module xcd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr_en,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_wdata,
	input  wire logic          q_not_empty,
	input  wire xcd_pkg::entry_t q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         plain_byte,
	output logic               plain_valid,
	output logic               done_res,
	output logic [1:0]         status
);
	import xcd_pkg::*;

	localparam int unsigned Rw = $clog2(XteaRounds);

	logic [31:0] key_q [4];
	logic [31:0] v0_q, v1_q, sum_q, crc_q;
	logic [Rw-1:0] rnd_q;
	logic        busy_q, blk_done_q;
	logic        out_vld_q;

	logic [31:0] v0_n, v1_n, sum_n, crc_n;
	logic [63:0] ks;
	logic [7:0]  plain;
	logic        start, out_free;
	status_t     fin;

	always_comb begin
		v0_n  = v0_q + ((((v1_q << 4) ^ (v1_q >> 5)) + v1_q) ^ (sum_q + key_q[sum_q[1:0]]));
		sum_n = sum_q + XteaDelta;
		v1_n  = v1_q + ((((v0_n << 4) ^ (v0_n >> 5)) + v0_n) ^ (sum_n + key_q[sum_n[12:11]]));
	end

	assign ks       = {v1_q, v0_q};
	assign plain    = q_head.data ^ ks[{q_head.lane, 3'b000} +: 8];
	assign out_free = !out_vld_q || out_ready;
	assign start    = q_not_empty && q_head.new_blk && !busy_q && !blk_done_q;
	assign q_pop    = q_not_empty && out_free && (!q_head.new_blk || blk_done_q);

	always_comb begin
		crc_n = crc_q ^ {24'b0, plain};
		for (int i = 0; i < 8; i++) begin
			crc_n = (crc_n >> 1) ^ (CrcPoly & {32{crc_n[0]}});
		end
		if (!q_head.emit) begin
			crc_n = crc_q;
		end
	end

	always_comb begin
		fin = q_head.pre_status;
		if ((q_head.pre_status == ST_OK) && ((~crc_n) != q_head.expected)) begin
			fin = ST_BAD_CRC;
		end
	end

	assign out_valid = out_vld_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			plain_byte  <= q_head.emit ? plain : 8'd0;
			plain_valid <= q_head.emit;
			done_res    <= q_head.last;
			status      <= q_head.last ? fin : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0]   <= KeyReset0;
			key_q[1]   <= KeyReset1;
			key_q[2]   <= KeyReset2;
			key_q[3]   <= KeyReset3;
			v0_q       <= '0;
			v1_q       <= '0;
			sum_q      <= '0;
			rnd_q      <= '0;
			busy_q     <= 1'b0;
			blk_done_q <= 1'b0;
			crc_q      <= '1;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					RegKey0: key_q[0] <= cfg_wdata;
					RegKey1: key_q[1] <= cfg_wdata;
					RegKey2: key_q[2] <= cfg_wdata;
					RegKey3: key_q[3] <= cfg_wdata;
					default: ;
				endcase
			end
			if (start) begin
				v0_q   <= q_head.ctr[31:0];
				v1_q   <= q_head.ctr[63:32];
				sum_q  <= '0;
				rnd_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				v0_q  <= v0_n;
				v1_q  <= v1_n;
				sum_q <= sum_n;
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == Rw'(XteaRounds - 1)) begin
					busy_q     <= 1'b0;
					blk_done_q <= 1'b1;
				end
			end
			if (q_pop) begin
				blk_done_q <= 1'b0;
				crc_q      <= q_head.last ? '1 : crc_n;
				out_vld_q  <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/xtea_ctr_container_decryptor.sv
// Top level of the XTEA-CTR container decryptor with CRC-32 check.
// Instantiates xcd_front, xcd_fifo and xcd_back; depends on xcd_pkg.
//
// The input channel takes one container byte per word, with last_byte set on
// the final byte. A result word comes out for every payload byte (plain_valid)
// and for the final byte (done_res with status); header bytes and bytes past
// the declared length give no word, nor do non-final bytes after a bad header
// or length. Results keep input order. A byte whose keystream block is on
// hand is written into the queue and then into the output register; the
// first byte of each 8-byte block waits at the queue head while the keystream
// unit runs one XTEA round per cycle over 32 rounds. Header bytes go at one
// per cycle while the queue is not full. A queue of FifoDepth words (four by
// default) separates the parser from the keystream unit, so bytes keep being
// accepted while a block is computed or the receiver stalls; when the queue
// fills, in_ready drops. A single output register holds a result until
// out_ready takes it. Reset clears the parser, CRC and queue and loads the
// default key and maximum length. Configuration writes take effect at once;
// the user makes them only while the block is idle; nothing enforces this.
`default_nettype none
module xtea_ctr_container_decryptor #(
	parameter int unsigned FifoDepth = xcd_pkg::FifoDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  file_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       plain_byte,
	output logic             plain_valid,
	output logic             done_res,
	output logic [1:0]       status
);
	import xcd_pkg::*;

	entry_t q_word, q_head;
	logic   q_push, q_pop, q_full, q_not_empty;

	xcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.file_byte (file_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_word    (q_word)
	);

	xcd_fifo #(
		.Width ($bits(entry_t)),
		.Depth (FifoDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_word),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_head)
	);

	xcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.plain_byte  (plain_byte),
		.plain_valid (plain_valid),
		.done_res    (done_res),
		.status      (status)
	);
endmodule
`default_nettype wire
